[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, always active.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

// Concurrent check sampled on the rising clock, off while reset is low.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

[hdl/psc_pkg.sv]
// Types, widths and constants of the pressure compensation pipeline.
`timescale 1ns / 1ps

package psc_pkg;

  // Register map
  localparam int NumRegs = 6;
  localparam int AddrW   = $clog2(4 * NumRegs);
  localparam int IdxW    = AddrW - 2;
  localparam int CalW    = 16;
  localparam int DataW   = 32;

  typedef enum logic [IdxW-1:0] {
    REG_SENS     = 0,
    REG_OFFSET   = 1,
    REG_TCS      = 2,
    REG_TCO      = 3,
    REG_TREF     = 4,
    REG_TEMPSENS = 5
  } reg_idx_e;

  // Algorithm constants
  localparam int TempBase = 2000;
  localparam int TempCold = -1500;
  localparam int ShTref   = 8;
  localparam int ShTemp   = 23;
  localparam int ShTco    = 7;
  localparam int ShTcs    = 8;
  localparam int ShOff    = 16;
  localparam int ShSensC  = 15;
  localparam int ShT2Lo   = 33;
  localparam int ShT2Hi   = 37;
  localparam int DivSens  = 2097152;
  localparam int DivPress = 32768;
  localparam int ShSens   = $clog2(DivSens);
  localparam int ShPress  = $clog2(DivPress);

  // Datapath widths
  localparam int RawW   = 24;
  localparam int DtW    = RawW + 1;
  localparam int MulW   = DtW + CalW + 1;
  localparam int SqW    = 2 * RawW;
  localparam int FloW   = MulW - ShTemp;
  localparam int TmpW   = FloW + 1;
  localparam int OffW   = 48;
  localparam int T2LoW  = SqW - ShT2Lo + 2;
  localparam int T2HiW  = SqW + 3 - ShT2Hi;
  localparam int DdW    = 2 * FloW;
  localparam int EeW    = 2 * TmpW;
  localparam int CorrW  = 46;
  localparam int Tmp2W  = TmpW + 1;
  localparam int SplitW = 24;
  localparam int PhW    = (OffW - SplitW) + DtW;
  localparam int PlW    = SplitW + RawW;
  localparam int SumW   = PhW + SplitW + 1;
  localparam int QW     = SumW - ShSens;
  localparam int RW     = QW + 1;
  localparam int PrW    = RW - ShPress;
  localparam int OutW   = 32;

  // Pipeline stages
  localparam int StgDt    = 0;
  localparam int StgMul   = 1;
  localparam int StgFirst = 2;
  localparam int StgSq    = 3;
  localparam int StgCorr  = 4;
  localparam int StgSub   = 5;
  localparam int StgPart  = 6;
  localparam int StgAcc   = 7;
  localparam int StgQuo   = 8;
  localparam int StgRem   = 9;
  localparam int StgPress = 10;
  localparam int NumStg   = 11;

  typedef struct packed {
    logic [CalW-1:0] sens;
    logic [CalW-1:0] offset;
    logic [CalW-1:0] tcs;
    logic [CalW-1:0] tco;
    logic [CalW-1:0] tref;
    logic [CalW-1:0] tempsens;
  } cal_t;

  typedef struct packed {
    logic [NumStg-1:0] ld;
    logic              in_rdy;
    logic              out_vld;
  } pipe_ctl_t;

  // First-order results
  typedef struct packed {
    logic signed [FloW-1:0] d;
    logic signed [TmpW-1:0] e;
    logic signed [TmpW-1:0] temp1;
    logic signed [OffW-1:0] off1;
    logic signed [OffW-1:0] sens1;
    logic [T2LoW-1:0]       t2lo;
    logic [T2HiW-1:0]       t2hi;
    logic                   low;
    logic                   cold;
    logic [RawW-1:0]        raw_press;
  } first_t;

  // Second-order corrected values
  typedef struct packed {
    logic signed [Tmp2W-1:0] temp2;
    logic signed [OffW-1:0]  off;
    logic signed [OffW-1:0]  sens;
    logic [RawW-1:0]         raw_press;
  } second_t;

endpackage

[hdl/psc_if.sv]
// Valid/ready channel interfaces for reading pairs and compensated results.
`timescale 1ns / 1ps

interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_temp;
  logic [23:0] raw_press;

  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface

interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temp_centi;
  logic signed [31:0] press_deci;

  modport source (output valid, output temp_centi, output press_deci, input ready);
  modport sink   (input valid, input temp_centi, input press_deci, output ready);
endinterface

[hdl/pressure_sensor_compensation_top.sv]
// Top level of the barometric second-order temperature compensation pipeline.
`timescale 1ns / 1ps
// Usage:
//   in_i  : one transaction carries a raw 24-bit temperature and pressure pair.
//   out_o : one transaction carries temp_centi (0.01 C) and press_deci (0.1 mbar),
//           both 32-bit two's complement, in input order.
//   APB   : six 16-bit calibration words at byte addresses 0x00..0x14
//           (sens, offset, tcs, tco, tref, tempsens); write them while the
//           pipeline is empty. pready is tied high, reads return the word.
// Timing:
//   Eleven register stages. One pair is taken per cycle in steady state while
//   the sink holds ready high. Depth is set by the chain dT -> dT*tempsens ->
//   TEMP -> (TEMP-20.00)^2 -> band correction -> SENS*D1 (two 24-bit partial
//   products) -> two truncating divides, with the multiplies and wide adds
//   spread across the stages.
// Stall:
//   When the sink holds ready low the output register keeps its transaction;
//   upstream stages keep filling empty slots, so in_i.ready only drops once
//   every stage holds a transaction.
// Reset:
//   rst_ni clears all stage valid bits and the calibration words to zero.

module pressure_sensor_compensation_top import psc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  psc_in_if.sink           in_i,
  psc_out_if.source        out_o
);

  cal_t      cal;
  pipe_ctl_t ctl;
  first_t    fo;
  second_t   so;

  // Calibration registers
  psc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  // Valid bits travel here; datapath registers only load on ctl.ld
  psc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl)
  );

  assign in_i.ready = ctl.in_rdy;

  // First-order compensation, three stages
  psc_first u_first (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .cal_i       (cal),
    .raw_temp_i  (in_i.raw_temp),
    .raw_press_i (in_i.raw_press),
    .first_o     (fo)
  );

  // Second-order band correction, three stages
  psc_second u_second (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .first_i  (fo),
    .second_o (so)
  );

  // Pressure product and divides, five stages ending in the output register
  psc_press u_press (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .second_i     (so),
    .temp_centi_o (out_o.temp_centi),
    .press_deci_o (out_o.press_deci)
  );

  assign out_o.valid = ctl.out_vld;

endmodule

[hdl/psc_cfg.sv]
// APB register file holding the six calibration words.
`timescale 1ns / 1ps

module psc_cfg import psc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cal_t             cal_o
);

  cal_t     cal_d, cal_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    cal_d = cal_q;
    if (wr) begin
      unique case (idx)
        REG_SENS:     cal_d.sens     = pwdata[CalW-1:0];
        REG_OFFSET:   cal_d.offset   = pwdata[CalW-1:0];
        REG_TCS:      cal_d.tcs      = pwdata[CalW-1:0];
        REG_TCO:      cal_d.tco      = pwdata[CalW-1:0];
        REG_TREF:     cal_d.tref     = pwdata[CalW-1:0];
        REG_TEMPSENS: cal_d.tempsens = pwdata[CalW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SENS:     prdata = DataW'(cal_q.sens);
      REG_OFFSET:   prdata = DataW'(cal_q.offset);
      REG_TCS:      prdata = DataW'(cal_q.tcs);
      REG_TCO:      prdata = DataW'(cal_q.tco);
      REG_TREF:     prdata = DataW'(cal_q.tref);
      REG_TEMPSENS: prdata = DataW'(cal_q.tempsens);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

[hdl/psc_ctrl.sv]
// Stage valid bits and per-stage load enables with bubble collapse.
`timescale 1ns / 1ps

module psc_ctrl import psc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [NumStg-1:0] vld_d, vld_q;
  logic [NumStg-1:0] en;

  // A stage may move when some stage at or downstream of it is empty, or the sink takes.
  always_comb begin
    for (int k = 0; k < NumStg; k++) begin
      en[k] = out_ready_i ||
              !(&(vld_q | ((NumStg'(1) << k) - NumStg'(1))));
    end
  end

  always_comb begin
    vld_d[0]    = en[0] ? in_valid_i : vld_q[0];
    ctl_o.ld[0] = en[0] && in_valid_i;
    for (int k = 1; k < NumStg; k++) begin
      vld_d[k]    = en[k] ? vld_q[k-1] : vld_q[k];
      ctl_o.ld[k] = en[k] && vld_q[k-1];
    end
    ctl_o.in_rdy  = en[0];
    ctl_o.out_vld = vld_q[NumStg-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

endmodule

[hdl/psc_first.sv]
// First-order stages: dT, calibration products, TEMP, OFF, SENS, T2 candidates.
`timescale 1ns / 1ps

module psc_first import psc_pkg::*; (
  input  logic            clk_i,
  input  pipe_ctl_t       ctl_i,
  input  cal_t            cal_i,
  input  logic [RawW-1:0] raw_temp_i,
  input  logic [RawW-1:0] raw_press_i,
  output first_t          first_o
);

  // stage: dT
  logic signed [DtW-1:0] dt_d, dt_q;
  logic [RawW-1:0]       rp0_q;

  assign dt_d = signed'({1'b0, raw_temp_i}) - signed'({1'b0, cal_i.tref, ShTref'(0)});

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgDt]) begin
      dt_q  <= dt_d;
      rp0_q <= raw_press_i;
    end
  end

  // stage: products of dT
  logic signed [MulW-1:0]  m_temp_d, m_temp_q;
  logic signed [MulW-1:0]  m_tco_d, m_tco_q;
  logic signed [MulW-1:0]  m_tcs_d, m_tcs_q;
  logic signed [SqW+1:0]   sq_full;
  logic [SqW-1:0]          sq_q;
  logic [RawW-1:0]         rp1_q;

  assign m_temp_d = dt_q * signed'({1'b0, cal_i.tempsens});
  assign m_tco_d  = dt_q * signed'({1'b0, cal_i.tco});
  assign m_tcs_d  = dt_q * signed'({1'b0, cal_i.tcs});
  assign sq_full  = dt_q * dt_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgMul]) begin
      m_temp_q <= m_temp_d;
      m_tco_q  <= m_tco_d;
      m_tcs_q  <= m_tcs_d;
      sq_q     <= sq_full[SqW-1:0];
      rp1_q    <= rp0_q;
    end
  end

  // stage: first-order values; floor shifts are arithmetic shifts
  logic signed [FloW-1:0]  flo;
  logic [SqW-ShT2Lo-1:0]   tsq;
  logic [SqW+2:0]          sq7;
  first_t                  first_d, first_q;

  always_comb begin
    flo             = m_temp_q[MulW-1:ShTemp];
    tsq             = sq_q[SqW-1:ShT2Lo];
    sq7             = {sq_q, 3'b000} - (SqW+3)'(sq_q);
    first_d.d       = flo;
    first_d.temp1   = TmpW'(flo) + TmpW'(TempBase);
    first_d.e       = TmpW'(flo) + TmpW'(TempBase - TempCold);
    first_d.low     = flo[FloW-1];
    first_d.cold    = first_d.temp1 < TmpW'(TempCold);
    first_d.off1    = signed'(OffW'({cal_i.offset, ShOff'(0)})) + OffW'(m_tco_q >>> ShTco);
    first_d.sens1   = signed'(OffW'({cal_i.sens, ShSensC'(0)})) + OffW'(m_tcs_q >>> ShTcs);
    first_d.t2lo    = T2LoW'(tsq) + {1'b0, tsq, 1'b0};
    first_d.t2hi    = sq7[SqW+2:ShT2Hi];
    first_d.raw_press = rp1_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgFirst]) begin
      first_q <= first_d;
    end
  end

  assign first_o = first_q;

endmodule

[hdl/psc_second.sv]
// Second-order stages: squares of the band distances, band select, corrected OFF/SENS.
`timescale 1ns / 1ps

module psc_second import psc_pkg::*; (
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  first_t    first_i,
  output second_t   second_o
);

  // stage: squares
  first_t         f_q;
  logic [DdW-1:0] dd_d, dd_q;
  logic [EeW-1:0] ee_d, ee_q;

  assign dd_d = DdW'(first_i.d * first_i.d);
  assign ee_d = EeW'(first_i.e * first_i.e);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgSq]) begin
      f_q  <= first_i;
      dd_q <= dd_d;
      ee_q <= ee_d;
    end
  end

  // stage: band select
  logic [CorrW-1:0]        dd3, dd5, ee7, ee4;
  logic [CorrW-1:0]        off2_d, sens2_d, off2_q, sens2_q;
  logic [T2LoW-1:0]        t2;
  logic signed [Tmp2W-1:0] temp2_d, temp2_q;
  logic signed [OffW-1:0]  off1_q, sens1_q;
  logic [RawW-1:0]         rp_q;

  always_comb begin
    dd3 = CorrW'({dd_q, 1'b0}) + CorrW'(dd_q);
    dd5 = CorrW'({dd_q, 2'b00}) + CorrW'(dd_q);
    ee7 = CorrW'({ee_q, 3'b000}) - CorrW'(ee_q);
    ee4 = CorrW'({ee_q, 2'b00});
    if (f_q.low) begin
      off2_d  = dd3 >> 1;
      sens2_d = dd5 >> 3;
      t2      = f_q.t2lo;
      if (f_q.cold) begin
        off2_d  = off2_d + ee7;
        sens2_d = sens2_d + ee4;
      end
    end else begin
      off2_d  = CorrW'(dd_q >> 4);
      sens2_d = '0;
      t2      = T2LoW'(f_q.t2hi);
    end
    temp2_d = Tmp2W'(f_q.temp1) - signed'(Tmp2W'(t2));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgCorr]) begin
      off2_q  <= off2_d;
      sens2_q <= sens2_d;
      temp2_q <= temp2_d;
      off1_q  <= f_q.off1;
      sens1_q <= f_q.sens1;
      rp_q    <= f_q.raw_press;
    end
  end

  // stage: corrected OFF and SENS
  second_t second_d, second_q;

  always_comb begin
    second_d.temp2     = temp2_q;
    second_d.off       = off1_q - signed'(OffW'(off2_q));
    second_d.sens      = sens1_q - signed'(OffW'(sens2_q));
    second_d.raw_press = rp_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgSub]) begin
      second_q <= second_d;
    end
  end

  assign second_o = second_q;

endmodule

[hdl/psc_press.sv]
// Pressure stages: split SENS*D1 product, truncating divides, output register.
`timescale 1ns / 1ps

module psc_press import psc_pkg::*; (
  input  logic                   clk_i,
  input  pipe_ctl_t              ctl_i,
  input  second_t                second_i,
  output logic signed [OutW-1:0] temp_centi_o,
  output logic signed [OutW-1:0] press_deci_o
);

  // stage: partial products, SENS cut into a signed high and unsigned low half
  logic signed [PhW-1:0]   ph_d, ph_q;
  logic [PlW-1:0]          pl_d, pl_q;
  logic signed [OffW-1:0]  off6_q;
  logic signed [Tmp2W-1:0] tmp6_q;

  assign ph_d = signed'(second_i.sens[OffW-1:SplitW]) * signed'({1'b0, second_i.raw_press});
  assign pl_d = second_i.sens[SplitW-1:0] * second_i.raw_press;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgPart]) begin
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      off6_q <= second_i.off;
      tmp6_q <= second_i.temp2;
    end
  end

  // stage: full product
  logic signed [SumW-1:0]  s_d, s_q;
  logic signed [OffW-1:0]  off7_q;
  logic signed [Tmp2W-1:0] tmp7_q;

  assign s_d = (SumW'(ph_q) <<< SplitW) + signed'(SumW'(pl_q));

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgAcc]) begin
      s_q    <= s_d;
      off7_q <= off6_q;
      tmp7_q <= tmp6_q;
    end
  end

  // stage: divide by 2^21 toward zero (floor, plus one for a negative inexact value)
  logic signed [QW-1:0]    q_d, q_q;
  logic                    q_adj;
  logic signed [OffW-1:0]  off8_q;
  logic signed [Tmp2W-1:0] tmp8_q;

  assign q_adj = s_q[SumW-1] && (s_q[ShSens-1:0] != '0);
  assign q_d   = QW'(s_q >>> ShSens) + signed'(QW'(q_adj));

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgQuo]) begin
      q_q    <= q_d;
      off8_q <= off7_q;
      tmp8_q <= tmp7_q;
    end
  end

  // stage: subtract OFF
  logic signed [RW-1:0]    r_d, r_q;
  logic signed [Tmp2W-1:0] tmp9_q;

  assign r_d = RW'(q_q) - RW'(off8_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgRem]) begin
      r_q    <= r_d;
      tmp9_q <= tmp8_q;
    end
  end

  // stage: divide by 2^15 toward zero, output register
  logic signed [PrW-1:0]  p_full;
  logic                   p_adj;
  logic signed [OutW-1:0] press_q, temp_q;

  assign p_adj  = r_q[RW-1] && (r_q[ShPress-1:0] != '0);
  assign p_full = PrW'(r_q >>> ShPress) + signed'(PrW'(p_adj));

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[StgPress]) begin
      press_q <= p_full[OutW-1:0];
      temp_q  <= OutW'(tmp9_q);
    end
  end

  assign temp_centi_o = temp_q;
  assign press_deci_o = press_q;

endmodule

[hdl/psc_checker.sv]
// Port-level checks of the compensation top level, bound to it below.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] temp_centi_i,
  input logic [31:0] press_deci_i,
  input logic        psel_i,
  input logic        pready_i
);

  // stalled result holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(temp_centi_i) && $stable(press_deci_i), "stalled result changed")
  // a free output slot lets the whole pipeline move
  `ASSERT_RST(a_in_ready, clk_i, rst_ni, (out_ready_i || !out_valid_i) |-> in_ready_i, "input blocked with free output")
  // reset empties the pipeline
  `ASSERT_CLK(a_rst_empty, clk_i, !rst_ni |=> !out_valid_i, "result valid right after reset")
  // register port never waits
  `ASSERT_CLK(a_pready, clk_i, psel_i |-> pready_i, "pready low during access")

endmodule

bind pressure_sensor_compensation_top psc_checker u_psc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .temp_centi_i (out_o.temp_centi),
  .press_deci_i (out_o.press_deci),
  .psel_i       (psel),
  .pready_i     (pready)
);
